/* src/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, sizes and codes of the round-robin task table scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int SLOTS     = 16;
   localparam int ID_BITS   = 16;
   localparam int TICK_BITS = 32;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(SLOTS + 1);

   localparam logic [2:0] KIND_CREATE    = 3'd0;
   localparam logic [2:0] KIND_TERMINATE = 3'd1;
   localparam logic [2:0] KIND_TICK      = 3'd2;
   localparam logic [2:0] KIND_YIELD     = 3'd3;
   localparam logic [2:0] KIND_SLEEP     = 3'd4;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_BUSY    = 2'd2;

   localparam logic [1:0] TS_READY      = 2'd0;
   localparam logic [1:0] TS_RUNNING    = 2'd1;
   localparam logic [1:0] TS_BLOCKED    = 2'd2;
   localparam logic [1:0] TS_TERMINATED = 2'd3;

   typedef struct packed {
      logic                 used;
      logic [ID_BITS-1:0]   id;
      logic [1:0]           state;
      logic [TICK_BITS-1:0] ticks;
      logic [TICK_BITS-1:0] wake;
   } entry_type;

   function automatic entry_type reset_entry(input int idx);
      entry_type e;
      e       = '0;
      if (idx < 2) begin
         e.used  = 1'b1;
         e.id    = ID_BITS'(idx);
         e.state = TS_RUNNING;
      end
      return e;
   endfunction

endpackage

/* src/rrts_cell.sv */
// ----------------------------------------------------------------------------
// rrts_cell
// One task table entry in the rotating ring; shifts toward the head on step.
// ----------------------------------------------------------------------------
module rrts_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  rrts_pkg::entry_type rst_val,
   input  rrts_pkg::entry_type d_in,
   output rrts_pkg::entry_type q
);
   import rrts_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= rst_val;
      end else if (shift) begin
         entry_ff <= d_in;
      end
   end

   assign q = entry_ff;

endmodule

/* src/round_robin_task_table_scheduler_top.sv */
// ----------------------------------------------------------------------------
// round_robin_task_table_scheduler_top
// Task table held in a ring of cells rotating past one head processing unit.
// ----------------------------------------------------------------------------
// Create, terminate and tick take one ring rotation; yield and sleep take up
// to three rotations (one per pass, one slot per cycle past the head).
// Unknown kinds are refused without rotating the ring. One item at a time.
// Reset (synchronous): slots 0 and 1 in use and running, running id 1, next
// id 2, clock 0, scheduling disabled.
// ----------------------------------------------------------------------------
module round_robin_task_table_scheduler_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [15:0] req_pid,
   input  logic [31:0] req_sleep_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_pid_out,
   output logic        rsp_switched,
   output logic [3:0]  rsp_from_slot,
   output logic [3:0]  rsp_to_slot,
   output logic [4:0]  rsp_active_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_sched_enable
);
   import rrts_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   entry_type cell_q [SLOTS];
   entry_type head_next;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           pass_ff, pass_in;
   logic [SLOT_BITS-1:0] step_ff, step_in;
   logic [2:0]           kind_ff;
   logic [15:0]          pid_ff;
   logic [TICK_BITS-1:0] dur_ff;
   logic                 found_ff, found_in;
   logic [SLOT_BITS-1:0] cur_ff, cur_in;
   logic                 bv_ff, bv_in;
   logic [SLOT_BITS-1:0] best_ff, best_in;
   logic [SLOT_BITS-1:0] bd_ff, bd_in;
   logic [ID_BITS-1:0]   bid_ff, bid_in;
   logic [1:0]           status_ff, status_in;
   logic                 sw_ff, sw_in;
   logic                 created_ff, created_in;
   logic [ID_BITS-1:0]   new_id_ff, new_id_in;
   logic [ID_BITS-1:0]   run_id_ff, run_id_in;
   logic [ID_BITS-1:0]   fresh_ff, fresh_in;
   logic [TICK_BITS-1:0] now_ff, now_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 sched_ff;
   logic                 rsp_valid_ff;
   logic                 shift;
   logic                 last_step;
   logic                 accept;
   logic                 load_out;
   logic [SLOT_BITS:0]   gap_w;
   logic [SLOT_BITS-1:0] gap;
   entry_type            h, e;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_ring
         rrts_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (shift),
            .rst_val (reset_entry(gi)),
            .d_in    ((gi == SLOTS - 1) ? head_next : cell_q[(gi + 1) % SLOTS]),
            .q       (cell_q[gi])
         );
      end
   endgenerate

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign shift     = (state_ff == S_RUN);
   assign last_step = (step_ff == SLOT_BITS'(SLOTS - 1));
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign h         = cell_q[0];

   always_comb begin
      if (step_ff > cur_ff) begin
         gap_w = {1'b0, step_ff} - {1'b0, cur_ff} - 1'b1;
      end else begin
         gap_w = {1'b0, step_ff} + (SLOT_BITS + 1)'(SLOTS) - {1'b0, cur_ff} - 1'b1;
      end
      gap = gap_w[SLOT_BITS-1:0];
   end

   always_comb begin
      state_in   = state_ff;
      pass_in    = pass_ff;
      step_in    = step_ff;
      found_in   = found_ff;
      cur_in     = cur_ff;
      bv_in      = bv_ff;
      best_in    = best_ff;
      bd_in      = bd_ff;
      bid_in     = bid_ff;
      status_in  = status_ff;
      sw_in      = sw_ff;
      created_in = created_ff;
      new_id_in  = new_id_ff;
      run_id_in  = run_id_ff;
      fresh_in   = fresh_ff;
      now_in     = now_ff;
      cnt_in     = cnt_ff;
      head_next  = h;
      e          = h;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pass_in    = 2'd0;
               step_in    = '0;
               found_in   = 1'b0;
               bv_in      = 1'b0;
               status_in  = STATUS_OK;
               sw_in      = 1'b0;
               created_in = 1'b0;
               state_in   = S_RUN;
               if (req_kind == KIND_TICK) begin
                  now_in = now_ff + 1'b1;
               end
               if (req_kind > KIND_SLEEP) begin
                  status_in = STATUS_REFUSED;
                  state_in  = S_DONE;
               end
            end
         end
         S_RUN: begin
            step_in = last_step ? '0 : step_ff + 1'b1;
            case (kind_ff)
               KIND_CREATE: begin
                  if (!h.used && !found_ff) begin
                     head_next       = '0;
                     head_next.used  = 1'b1;
                     head_next.id    = fresh_ff;
                     head_next.state = TS_READY;
                     found_in        = 1'b1;
                     created_in      = 1'b1;
                     new_id_in       = fresh_ff;
                     fresh_in        = fresh_ff + 1'b1;
                     cnt_in          = cnt_ff + 1'b1;
                  end
                  if (last_step) begin
                     status_in = found_in ? STATUS_OK : STATUS_REFUSED;
                     state_in  = S_DONE;
                  end
               end
               KIND_TERMINATE: begin
                  if (h.used && h.id == ID_BITS'(pid_ff) && !found_ff) begin
                     found_in = 1'b1;
                     if (pid_ff > 16'd1) begin
                        head_next.state = TS_TERMINATED;
                        head_next.used  = 1'b0;
                        cnt_in          = cnt_ff - 1'b1;
                     end
                  end
                  if (last_step) begin
                     status_in = (found_in && pid_ff > 16'd1) ? STATUS_OK : STATUS_REFUSED;
                     state_in  = S_DONE;
                  end
               end
               KIND_TICK: begin
                  if (h.used && h.id == run_id_ff && !found_ff) begin
                     found_in        = 1'b1;
                     head_next.ticks = h.ticks + 1'b1;
                  end
                  if (h.used && h.state == TS_BLOCKED && h.wake != '0 && now_ff >= h.wake) begin
                     head_next.state = TS_READY;
                     head_next.wake  = '0;
                  end
                  if (last_step) begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  if (pass_ff == 2'd0) begin
                     if (h.used && h.id == run_id_ff && !found_ff) begin
                        found_in = 1'b1;
                        cur_in   = step_ff;
                     end
                     if (last_step) begin
                        pass_in = 2'd1;
                        if (!found_in) begin
                           cur_in = '0;
                        end
                        if (kind_ff == KIND_SLEEP) begin
                           if (!found_in || run_id_ff <= ID_BITS'(1)) begin
                              status_in = STATUS_BUSY;
                              state_in  = S_DONE;
                           end
                        end else if (!sched_ff) begin
                           state_in = S_DONE;
                        end
                     end
                  end else if (pass_ff == 2'd1) begin
                     if (kind_ff == KIND_SLEEP && step_ff == cur_ff) begin
                        head_next.state = TS_BLOCKED;
                        head_next.wake  = now_ff + dur_ff;
                     end
                     e = head_next;
                     if (e.used && e.state == TS_READY && (!bv_ff || gap < bd_ff)) begin
                        bv_in   = 1'b1;
                        best_in = step_ff;
                        bd_in   = gap;
                        bid_in  = e.id;
                     end
                     if (last_step) begin
                        pass_in = 2'd2;
                        if (!sched_ff || !bv_in || best_in == cur_ff) begin
                           state_in = S_DONE;
                        end
                     end
                  end else begin
                     if (step_ff == cur_ff && h.state == TS_RUNNING) begin
                        head_next.state = TS_READY;
                     end
                     if (step_ff == best_ff) begin
                        head_next.state = TS_RUNNING;
                     end
                     if (last_step) begin
                        run_id_in = bid_ff;
                        sw_in     = 1'b1;
                        state_in  = S_DONE;
                     end
                  end
               end
            endcase
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= 2'd0;
         step_ff      <= '0;
         run_id_ff    <= ID_BITS'(1);
         fresh_ff     <= ID_BITS'(2);
         now_ff       <= '0;
         cnt_ff       <= CNT_BITS'(2);
         sched_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pass_ff   <= pass_in;
         step_ff   <= step_in;
         run_id_ff <= run_id_in;
         fresh_ff  <= fresh_in;
         now_ff    <= now_in;
         cnt_ff    <= cnt_in;
         if (csr_valid && csr_ready) begin
            sched_ff <= csr_sched_enable;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      cur_ff     <= cur_in;
      bv_ff      <= bv_in;
      best_ff    <= best_in;
      bd_ff      <= bd_in;
      bid_ff     <= bid_in;
      status_ff  <= status_in;
      sw_ff      <= sw_in;
      created_ff <= created_in;
      new_id_ff  <= new_id_in;
      if (accept) begin
         kind_ff <= req_kind;
         pid_ff  <= req_pid;
         dur_ff  <= TICK_BITS'(req_sleep_ticks);
      end
      if (load_out) begin
         rsp_status       <= status_ff;
         rsp_pid_out      <= 16'(created_ff ? new_id_ff : run_id_ff);
         rsp_switched     <= sw_ff;
         rsp_from_slot    <= sw_ff ? 4'(cur_ff) : 4'd0;
         rsp_to_slot      <= sw_ff ? 4'(best_ff) : 4'd0;
         rsp_active_count <= 5'(cnt_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
